// File: sv/imf_pkg.sv
// Shared constants, types and the exponential ROM for the Metropolis flip unit.
package imf_pkg;
    localparam int MAX_SPINS       = 64;
    localparam int SPIN_IDX_W      = $clog2(MAX_SPINS);
    localparam int COUNT_W         = SPIN_IDX_W + 1;
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
    localparam int ADDR_W          = 2 * SPIN_IDX_W;
    localparam int COUPLE_W        = 16;
    localparam int DE_W            = 23;
    localparam int TE_W            = 27;
    localparam int ROW_W           = COUPLE_W + SPIN_IDX_W + 1;
    localparam int TOT_W           = ROW_W + SPIN_IDX_W + 1;
    localparam int BETA_W          = 16;
    localparam int PROD_W          = BETA_W + DE_W - 1;
    localparam int EXP_SHIFT       = 18;

    localparam logic [1:0] ACT_WR_COUPLING = 2'd0;
    localparam logic [1:0] ACT_WR_SPIN     = 2'd1;
    localparam logic [1:0] ACT_FLIP        = 2'd2;
    localparam logic [1:0] ACT_ENERGY      = 2'd3;

    localparam logic [1:0] CFG_ACTIVE_SPINS = 2'd0;
    localparam logic [1:0] CFG_INV_TEMP     = 2'd1;

    typedef logic [15:0] exp_rom_t [EXP_TABLE_DEPTH];

    // Build exp(-i/16) in Q0.16 by repeated Q0.32 multiplication.
    function automatic exp_rom_t build_exp_rom();
        exp_rom_t   rom;
        logic [63:0] q;
        logic [63:0] e;
        q = 64'd1 << 32;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            if (i > 0) begin
                q = (q * 64'd4034748382 + (64'd1 << 31)) >> 32;
            end
            e = (q + 64'd32768) >> 16;
            rom[i] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
        end
        return rom;
    endfunction

    localparam exp_rom_t EXP_ROM = build_exp_rom();
endpackage

// File: sv/imf_spin_cell.sv
// One spin cell of the rotating spin chain.
module imf_spin_cell (
    input  logic aclk,
    input  logic aresetn,
    input  logic shift_en,
    input  logic shift_in,
    input  logic load_en,
    input  logic load_val,
    output logic spin
);
    logic spin_reg;
    logic spin_next;

    // Take the neighbor's spin on a shift, or a direct load at rest.
    always_comb begin
        spin_next = spin_reg;
        if (shift_en) begin
            spin_next = shift_in;
        end else if (load_en) begin
            spin_next = load_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spin_reg <= 1'b0;
        end else begin
            spin_reg <= spin_next;
        end
    end

    assign spin = spin_reg;
endmodule

// File: sv/ising_metropolis_flip_unit.sv
// Top level of the Metropolis spin-flip unit for an Ising spin glass.
// Write items (coupling or spin) are answered without a row walk. A flip walks one coupling row of
// 64 entries through the single coupling RAM read port while the spin chain rotates past its
// head cell; an energy report walks every active row that way. One item is in work at a time,
// and the next is taken once the result register is free or being emptied.
module ising_metropolis_flip_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [15:0]                       cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_action,
    input  logic [imf_pkg::SPIN_IDX_W-1:0]    s_row_index,
    input  logic [imf_pkg::SPIN_IDX_W-1:0]    s_col_index,
    input  logic signed [imf_pkg::COUPLE_W-1:0] s_coupling_value,
    input  logic                              s_spin_value,
    input  logic [15:0]                       s_uniform_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_accepted,
    output logic signed [imf_pkg::DE_W-1:0]   m_delta_energy,
    output logic signed [imf_pkg::TE_W-1:0]   m_total_energy
);
    import imf_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WALK   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_FIN    = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_DECIDE = 3'd5;
    localparam logic [2:0] ST_ESAT   = 3'd6;

    logic [2:0]              state_reg;
    logic [COUNT_W-1:0]      active_reg;
    logic [BETA_W-1:0]       beta_reg;
    logic                    flip_mode_reg;
    logic [SPIN_IDX_W-1:0]   row_reg;
    logic [15:0]             u_reg;
    logic [COUNT_W-1:0]      j_reg;
    logic                    pv_reg;
    logic                    ps_reg;
    logic signed [COUPLE_W-1:0] rd_reg;
    logic signed [ROW_W-1:0] row_acc_reg;
    logic signed [TOT_W-1:0] tot_reg;
    logic signed [DE_W-1:0]  de_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    out_valid_reg;
    logic                    out_acc_reg;
    logic signed [DE_W-1:0]  out_de_reg;
    logic signed [TE_W-1:0]  out_te_reg;

    logic [COUPLE_W-1:0]     cmem [MAX_SPINS * MAX_SPINS];

    logic [MAX_SPINS-1:0]    spins;
    logic [MAX_SPINS-1:0]    load_en;
    logic                    load_val;
    logic                    shift_en;
    logic [COUNT_W-1:0]      n_used;
    logic                    accept;
    logic                    instant_done;
    logic                    res_load;
    logic                    spin_row;
    logic signed [ROW_W+2:0] de_full;
    logic signed [DE_W-1:0]  de_sat;
    logic signed [TOT_W:0]   neg_tot;
    logic signed [TE_W-1:0]  te_sat;
    logic [PROD_W-EXP_SHIFT-1:0] exp_idx;
    logic [15:0]             thr;
    logic                    keep;

    assign n_used   = (active_reg > COUNT_W'(MAX_SPINS)) ? COUNT_W'(MAX_SPINS) : active_reg;
    assign s_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign shift_en = (state_reg == ST_WALK);
    assign spin_row = spins[row_reg];

    // Beats that answer at once: writes, inactive flips, empty energy reports.
    assign instant_done = accept &&
                          !(s_action == ACT_FLIP && COUNT_W'(s_row_index) < n_used) &&
                          !(s_action == ACT_ENERGY && n_used != '0);
    assign res_load     = instant_done || (state_reg == ST_DECIDE) || (state_reg == ST_ESAT);

    // Spin chain: each cell hands its spin to the one below, the head wraps to the tail.
    for (genvar k = 0; k < MAX_SPINS; k++) begin : g_cell
        imf_spin_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .shift_in (spins[(k + 1) % MAX_SPINS]),
            .load_en  (load_en[k]),
            .load_val (load_val),
            .spin     (spins[k])
        );
    end

    // Direct spin loads: a spin write beat, or a kept flip.
    always_comb begin
        load_en  = '0;
        load_val = 1'b0;
        if (accept && s_action == ACT_WR_SPIN) begin
            load_en[s_row_index] = 1'b1;
            load_val             = s_spin_value;
        end else if (state_reg == ST_DECIDE && keep) begin
            load_en[row_reg] = 1'b1;
            load_val         = ~spin_row;
        end
    end

    // Saturate the flip energy change and the negated total.
    always_comb begin
        de_full = spin_row ? ((ROW_W+3)'(row_acc_reg) <<< 2) : -((ROW_W+3)'(row_acc_reg) <<< 2);
        if (de_full > (ROW_W+3)'(4194303)) begin
            de_sat = DE_W'(4194303);
        end else if (de_full < -(ROW_W+3)'(4194304)) begin
            de_sat = -DE_W'(4194304);
        end else begin
            de_sat = de_full[DE_W-1:0];
        end
        neg_tot = -(TOT_W+1)'(tot_reg);
        if (neg_tot > (TOT_W+1)'(67108863)) begin
            te_sat = TE_W'(67108863);
        end else if (neg_tot < -(TOT_W+1)'(67108864)) begin
            te_sat = -TE_W'(67108864);
        end else begin
            te_sat = neg_tot[TE_W-1:0];
        end
    end

    // Acceptance test against the exponential ROM.
    always_comb begin
        exp_idx = prod_reg[PROD_W-1:EXP_SHIFT];
        if (exp_idx < (PROD_W-EXP_SHIFT)'(EXP_TABLE_DEPTH)) begin
            thr = EXP_ROM[exp_idx[EXP_IDX_W-1:0]];
        end else begin
            thr = 16'd0;
        end
        keep = de_reg[DE_W-1] || (u_reg < thr);
    end

    // Coupling RAM: write on a coupling beat, read one entry of the walked row a cycle.
    always_ff @(posedge aclk) begin
        if (accept && s_action == ACT_WR_COUPLING) begin
            cmem[{s_row_index, s_col_index}] <= s_coupling_value;
        end
        rd_reg <= cmem[{row_reg, j_reg[SPIN_IDX_W-1:0]}];
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= COUNT_W'(MAX_SPINS);
            beta_reg   <= BETA_W'(256);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ACTIVE_SPINS: active_reg <= cfg_data[COUNT_W-1:0];
                CFG_INV_TEMP:     beta_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Sequencer: walk rows, accumulate, decide, deliver.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            // Hold the result beat until taken, load a new one when it is ready.
            if (res_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            pv_reg <= (state_reg == ST_WALK) && (j_reg < n_used) &&
                      !(flip_mode_reg && j_reg[SPIN_IDX_W-1:0] == row_reg);
            ps_reg <= spins[0];
            if (pv_reg) begin
                row_acc_reg <= ps_reg ? row_acc_reg + ROW_W'(rd_reg)
                                      : row_acc_reg - ROW_W'(rd_reg);
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        row_reg       <= (s_action == ACT_ENERGY) ? '0 : s_row_index;
                        u_reg         <= s_uniform_sample;
                        j_reg         <= '0;
                        row_acc_reg   <= '0;
                        tot_reg       <= '0;
                        flip_mode_reg <= (s_action == ACT_FLIP);
                        if (s_action == ACT_FLIP && COUNT_W'(s_row_index) < n_used) begin
                            state_reg <= ST_WALK;
                        end else if (s_action == ACT_ENERGY && n_used != '0) begin
                            state_reg <= ST_WALK;
                        end else begin
                            out_acc_reg   <= 1'b0;
                            out_de_reg    <= '0;
                            out_te_reg    <= '0;
                        end
                    end
                end
                ST_WALK: begin
                    j_reg  <= j_reg + 1'b1;
                    if (j_reg == COUNT_W'(MAX_SPINS - 1)) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (flip_mode_reg) begin
                        de_reg    <= de_sat;
                        state_reg <= ST_MUL;
                    end else begin
                        tot_reg     <= spin_row ? tot_reg + TOT_W'(row_acc_reg)
                                                : tot_reg - TOT_W'(row_acc_reg);
                        row_acc_reg <= '0;
                        j_reg       <= '0;
                        if (COUNT_W'(row_reg) == n_used - 1'b1) begin
                            state_reg <= ST_ESAT;
                        end else begin
                            row_reg   <= row_reg + 1'b1;
                            state_reg <= ST_WALK;
                        end
                    end
                end
                ST_MUL: begin
                    prod_reg  <= PROD_W'(beta_reg) * PROD_W'(de_reg[DE_W-2:0]);
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    out_acc_reg   <= keep;
                    out_de_reg    <= de_reg;
                    out_te_reg    <= '0;
                    state_reg     <= ST_IDLE;
                end
                ST_ESAT: begin
                    out_acc_reg   <= 1'b0;
                    out_de_reg    <= '0;
                    out_te_reg    <= te_sat;
                    state_reg     <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_accepted     = out_acc_reg;
    assign m_delta_energy = out_de_reg;
    assign m_total_energy = out_te_reg;
endmodule

// File: sim/imf_flip_checker.sv
// Scoreboard for the Metropolis flip unit: mirrors the spin glass state and checks every result.
module imf_flip_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [5:0]  s_row_index,
    input  logic [5:0]  s_col_index,
    input  logic signed [15:0] s_coupling_value,
    input  logic        s_spin_value,
    input  logic [15:0] s_uniform_sample,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_accepted,
    input  logic signed [22:0] m_delta_energy,
    input  logic signed [26:0] m_total_energy,
    output int          pending,
    output int          mismatches
);
    import imf_pkg::*;

    typedef struct packed {
        logic               accepted;
        logic signed [22:0] delta_energy;
        logic signed [26:0] total_energy;
    } flip_result_t;

    localparam longint DE_HI = 64'sd4194303;
    localparam longint DE_LO = -64'sd4194304;
    localparam longint TE_HI = 64'sd67108863;
    localparam longint TE_LO = -64'sd67108864;

    logic signed [15:0] couplings [64][64];
    logic [63:0]        spins;
    logic [6:0]         active_spins;
    logic [15:0]        inv_temp;
    logic [15:0]        boltzmann_rom [256];
    flip_result_t       expected_results [$];

    assign pending = expected_results.size();

    // Build the exp(-i/16) threshold table in Q0.16
    initial begin
        logic [63:0] q;
        logic [63:0] e;
        q = 64'd1 << 32;
        for (int i = 0; i < 256; i++) begin
            if (i > 0) q = (q * 64'd4034748382 + (64'd1 << 31)) >> 32;
            e = (q + 64'd32768) >> 16;
            boltzmann_rom[i] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
        end
        mismatches = 0;
    end

    function automatic longint spin_sign(int i);
        return spins[i] ? 64'sd1 : -64'sd1;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Apply one beat to the mirrored state and compute what it returns
    task automatic predict_beat();
        flip_result_t res;
        int           nn;
        longint       field;
        longint       de;
        longint       acc;
        longint       row_sum;
        longint       idx;
        logic [15:0]  thr;
        logic         keep;
        res = '0;
        nn = (active_spins > 7'd64) ? 64 : int'(active_spins);
        case (s_action)
            ACT_WR_COUPLING: couplings[s_row_index][s_col_index] = s_coupling_value;
            ACT_WR_SPIN:     spins[s_row_index] = s_spin_value;
            ACT_FLIP: begin
                if (int'(s_row_index) < nn) begin
                    field = 0;
                    for (int j = 0; j < nn; j++)
                        if (j != int'(s_row_index))
                            field += longint'(couplings[s_row_index][j]) * spin_sign(j);
                    de = clamp(4 * spin_sign(s_row_index) * field, DE_LO, DE_HI);
                    if (de < 0) begin
                        keep = 1'b1;
                    end else begin
                        idx = (longint'(inv_temp) * de) >>> 18;
                        thr = (idx < 256) ? boltzmann_rom[idx] : 16'd0;
                        keep = s_uniform_sample < thr;
                    end
                    if (keep) spins[s_row_index] = ~spins[s_row_index];
                    res.accepted = keep;
                    res.delta_energy = de[22:0];
                end
            end
            default: begin
                acc = 0;
                for (int i = 0; i < nn; i++) begin
                    row_sum = 0;
                    for (int j = 0; j < nn; j++)
                        row_sum += longint'(couplings[i][j]) * spin_sign(j);
                    acc += spin_sign(i) * row_sum;
                end
                acc = clamp(-acc, TE_LO, TE_HI);
                res.total_energy = acc[26:0];
            end
        endcase
        expected_results.insert(expected_results.size(), res);
    endtask

    // Compare a result beat against the oldest expectation
    task automatic check_result();
        flip_result_t exp_r;
        if (expected_results.size() == 0) begin
            if (mismatches < 10)
                $display("unexpected result beat: acc=%0d dE=%0d E=%0d",
                         m_accepted, m_delta_energy, m_total_energy);
            mismatches++;
            return;
        end
        exp_r = expected_results.pop_front();
        if (exp_r.accepted !== m_accepted || exp_r.delta_energy !== m_delta_energy ||
            exp_r.total_energy !== m_total_energy) begin
            if (mismatches < 10)
                $display("mismatch: expected acc=%0d dE=%0d E=%0d, got acc=%0d dE=%0d E=%0d",
                         exp_r.accepted, exp_r.delta_energy, exp_r.total_energy,
                         m_accepted, m_delta_energy, m_total_energy);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            spins = '0;
            active_spins = 7'd64;
            inv_temp = 16'd256;
            expected_results.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_ACTIVE_SPINS) active_spins = cfg_data[6:0];
                else if (cfg_index == CFG_INV_TEMP) inv_temp = cfg_data;
            end
            if (m_valid && m_ready) check_result();
            if (s_valid && s_ready) predict_beat();
        end
    end
endmodule

// File: sim/tb_ising_metropolis_flip_unit.sv
// Stimulus and verdict for the Metropolis spin-flip unit.
module tb_ising_metropolis_flip_unit;
    import imf_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_action;
    logic [5:0]  s_row_index;
    logic [5:0]  s_col_index;
    logic signed [15:0] s_coupling_value;
    logic        s_spin_value;
    logic [15:0] s_uniform_sample;
    logic        m_valid;
    logic        m_ready;
    logic        m_accepted;
    logic signed [22:0] m_delta_energy;
    logic signed [26:0] m_total_energy;
    int          pending;
    int          mismatches;
    logic        quiet;
    int          sink_stall;
    int          nn;

    ising_metropolis_flip_unit u_dut (.*);

    imf_flip_checker u_checker (.*);

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Throttle the result side in random bursts
    always @(negedge aclk) begin
        if (quiet || !aresetn) begin
            m_ready <= 1'b1;
        end else if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            sink_stall <= $urandom_range(0, 10);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        #200000000;
        $display("TB_ERROR");
        $finish;
    end

    // Drive one beat and hold it until accepted
    task automatic send(logic [1:0] act, logic [5:0] row, logic [5:0] col,
                        logic [15:0] cval, logic sv, logic [15:0] u);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_action = act;
        s_row_index = row;
        s_col_index = col;
        s_coupling_value = cval;
        s_spin_value = sv;
        s_uniform_sample = u;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Wait for the block to go quiet, then reconfigure
    task automatic config_phase(int count, logic [15:0] beta);
        drain();
        write_reg(CFG_ACTIVE_SPINS, 16'(count));
        write_reg(CFG_INV_TEMP, beta);
        nn = (count > 64) ? 64 : count;
    endtask

    // Reconfigure and load the whole active coupling block with random values
    task automatic start_phase(int count, logic [15:0] beta);
        config_phase(count, beta);
        for (int i = 0; i < nn; i++)
            for (int j = 0; j < nn; j++)
                send(ACT_WR_COUPLING, 6'(i), 6'(j), 16'($urandom), 1'($urandom),
                     16'($urandom));
    endtask

    // Fill one full coupling row with a single value
    task automatic load_row(logic [5:0] row, logic [15:0] val);
        for (int j = 0; j < 64; j++)
            send(ACT_WR_COUPLING, row, 6'(j), val, 1'($urandom), 16'($urandom));
    endtask

    // Random traffic; flips mostly target active particles
    task automatic random_beats(int count);
        int  pick;
        logic [5:0] row;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            row = 6'($urandom);
            if (pick >= 45 && nn > 0 && $urandom_range(0, 3) != 0)
                row = 6'($urandom_range(0, nn - 1));
            if (pick < 20)
                send(ACT_WR_COUPLING, row, 6'($urandom), 16'($urandom), 1'($urandom),
                     16'($urandom));
            else if (pick < 45)
                send(ACT_WR_SPIN, row, 6'($urandom), 16'($urandom), 1'($urandom),
                     16'($urandom));
            else if (pick < 90)
                send(ACT_FLIP, row, 6'($urandom), 16'($urandom), 1'($urandom),
                     ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom));
            else
                send(ACT_ENERGY, row, 6'($urandom), 16'($urandom), 1'($urandom),
                     16'($urandom));
        end
    endtask

    initial begin
        aresetn = 1'b0;
        quiet = 1'b0;
        sink_stall = 0;
        cfg_we = 1'b0;
        cfg_index = CFG_ACTIVE_SPINS;
        cfg_data = '0;
        s_valid = 1'b0;
        s_action = ACT_WR_COUPLING;
        s_row_index = '0;
        s_col_index = '0;
        s_coupling_value = '0;
        s_spin_value = 1'b0;
        s_uniform_sample = '0;
        nn = 64;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        // Saturated energy changes; every spin is still -1 out of reset
        config_phase(100, 16'd256);
        load_row(6'd3, 16'sd32767);
        load_row(6'd63, -16'sd32768);
        send(ACT_FLIP, 6'd3, 6'd0, 16'd0, 1'b0, 16'd0);
        send(ACT_FLIP, 6'd63, 6'd0, 16'd0, 1'b0, 16'hFFFF);
        send(ACT_FLIP, 6'd63, 6'd0, 16'd0, 1'b0, 16'd0);

        // Directed: field extremes, every action, inactive particle
        start_phase(8, 16'd256);
        send(ACT_WR_COUPLING, 6'd63, 6'd63, -16'sd32768, 1'b0, 16'd0);
        send(ACT_WR_COUPLING, 6'd0, 6'd0, 16'sd32767, 1'b1, 16'hFFFF);
        send(ACT_WR_SPIN, 6'd63, 6'd0, 16'd0, 1'b1, 16'd0);
        send(ACT_WR_SPIN, 6'd0, 6'd63, 16'hFFFF, 1'b0, 16'hFFFF);
        send(ACT_FLIP, 6'd0, 6'd0, 16'd0, 1'b0, 16'd0);
        send(ACT_FLIP, 6'd0, 6'd0, 16'd0, 1'b0, 16'hFFFF);
        send(ACT_FLIP, 6'd7, 6'd0, 16'd0, 1'b0, 16'd0);
        send(ACT_FLIP, 6'd63, 6'd0, 16'd0, 1'b0, 16'd0);
        send(ACT_ENERGY, 6'd0, 6'd0, 16'd0, 1'b0, 16'd0);
        random_beats(90);

        start_phase(1, 16'd0);
        random_beats(25);
        start_phase(0, 16'd65535);
        random_beats(15);
        start_phase(10, 16'd65535);
        random_beats(50);
        start_phase(5, 16'd4);
        random_beats(50);
        start_phase(6, 16'($urandom));
        random_beats(20);
        quiet = 1'b1;
        random_beats(40);

        drain();
        repeat (100) @(negedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
